// File: rtl/shrbh_pkg.sv
`timescale 1ns / 1ps
package shrbh_pkg;
    localparam int CfgRegs = 5;
    localparam int CfgIdxW = 3;
    localparam int QueueDepth = 4;
    localparam logic [CfgIdxW-1:0] REG_AB  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CD  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_EF  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GH  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_LEN = 3'd4;
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Work word from front to back: one 32-bit message word, with flags
    typedef struct packed {
        logic        start;   // load chaining state first
        logic        last;    // final block word 15 -> emit digest
        logic [31:0] word;
    } shrbh_word_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction
endpackage

// File: rtl/sha256_resumable_byte_hasher.sv
`timescale 1ns / 1ps
// SHA-256 over a byte stream that resumes from a chaining value and byte
// count written through the configuration port; the count is picked up at
// the first beat of each message, the chaining value when the engine loads
// the message's first word. Absorb beats take one byte each; a finish beat
// pads and, after the last compression, eight digest words come out in
// order, word 0 first. The front end packs bytes into 32-bit words and
// makes the padding; a four-word queue decouples it from the round engine,
// which runs one round per cycle, stalling in rounds 0..15 while the queue
// is empty, 64 rounds per 64-byte block. Streaming bytes see one byte per
// cycle while the queue has room, but the queue only covers 16 bytes of the
// 48 late rounds, so a steady stream is held back by the engine. A finish
// costs up to two block compressions before the first digest word appears,
// and new beats are refused while the digest waits to be read.
module sha256_resumable_byte_hasher
    import shrbh_pkg::*;
#(
    parameter int QDepth = QueueDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               func,
    input  logic [7:0]         data_byte,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [63:0]        cfg_data
);
    logic [63:0] cfg_reg [CfgRegs];
    logic        wr_en, rd_en, q_full, q_valid, f_full;
    shrbh_word_t wr_word, rd_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CfgRegs; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_AB:  cfg_reg[0] <= cfg_data;
                REG_CD:  cfg_reg[1] <= cfg_data;
                REG_EF:  cfg_reg[2] <= cfg_data;
                REG_GH:  cfg_reg[3] <= cfg_data;
                REG_LEN: cfg_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // front end held off while digest waits
    assign full = f_full || !empty;

    shrbh_front u_front (
        .clk, .rst_n,
        .push      (push && empty),
        .full      (f_full),
        .func, .data_byte,
        .start_len (cfg_reg[4]),
        .wr_en, .wr_word, .q_full
    );

    shrbh_queue #(.Depth(QDepth)) u_queue (
        .clk, .rst_n, .wr_en, .wr_word, .q_full,
        .rd_en, .q_valid, .rd_word
    );

    shrbh_core u_core (
        .clk, .rst_n, .q_valid, .rd_word, .rd_en,
        .chain_cfg ({cfg_reg[0], cfg_reg[1], cfg_reg[2], cfg_reg[3]}),
        .empty, .pop, .digest_word, .word_index, .last_word
    );
endmodule

// File: rtl/shrbh_front.sv
`timescale 1ns / 1ps
// Packs bytes into words, generates padding, tracks length.
module shrbh_front
    import shrbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic [63:0] start_len,
    output logic        wr_en,
    output shrbh_word_t wr_word,
    input  logic        q_full
);
    localparam logic [1:0] ST_BYTES = 2'd0;
    localparam logic [1:0] ST_PAD   = 2'd1;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] total_reg, total_next;
    logic        fresh_reg, fresh_next;
    logic        start_reg, start_next;   // start flag pending for next word
    logic [23:0] acc_reg, acc_next;
    logic [63:0] bits_reg, bits_next;

    logic        accept;
    logic [63:0] tot_cur;
    logic        start_cur;
    logic [7:0]  pad_byte;
    logic [31:0] pad_word;
    logic [3:0]  widx;

    assign full   = (state_reg != ST_BYTES) || q_full;
    assign accept = push && !full;
    assign widx   = fill_reg[5:2];

    always_comb
    begin
        tot_cur   = fresh_reg ? start_len : total_reg;
        start_cur = fresh_reg || start_reg;
        // padding word at fill (word-aligned in ST_PAD)
        if (widx == 4'd14)
            pad_word = bits_reg[63:32];
        else if (widx == 4'd15)
            pad_word = bits_reg[31:0];
        else
            pad_word = 32'd0;
        pad_byte = 8'h80;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        fresh_next = fresh_reg;
        start_next = start_reg;
        acc_next   = acc_reg;
        bits_next  = bits_reg;
        wr_en      = 1'b0;
        wr_word    = '0;
        case (state_reg)
            ST_BYTES:
            begin
                if (accept)
                begin
                    fresh_next = 1'b0;
                    start_next = start_cur;
                    if (func == FUNC_ABSORB)
                    begin
                        total_next = tot_cur + 64'd1;
                        fill_next  = fill_reg + 6'd1;
                        case (fill_reg[1:0])
                            2'd0: acc_next[23:16] = data_byte;
                            2'd1: acc_next[15:8]  = data_byte;
                            2'd2: acc_next[7:0]   = data_byte;
                            default:
                            begin
                                wr_en      = 1'b1;
                                wr_word    = '{start: start_cur, last: 1'b0,
                                               word: {acc_reg, data_byte}};
                                start_next = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        total_next = tot_cur;
                        bits_next  = {tot_cur[60:0], 3'b000};
                        // put 0x80 then zeros to the word boundary
                        wr_en = 1'b1;
                        case (fill_reg[1:0])
                            2'd0: wr_word.word = {pad_byte, 24'd0};
                            2'd1: wr_word.word = {acc_reg[23:16], pad_byte, 16'd0};
                            2'd2: wr_word.word = {acc_reg[23:8], pad_byte, 8'd0};
                            default: wr_word.word = {acc_reg, pad_byte};
                        endcase
                        wr_word.start = start_cur;
                        wr_word.last  = 1'b0;
                        start_next    = 1'b0;
                        fill_next     = {fill_reg[5:2] + 4'd1, 2'b00};
                        state_next    = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // if the 0x80 word landed in words 14 or 15, a zero-filled
                // block comes first; words 14/15 of the last block carry length
                if (!q_full)
                begin
                    wr_en = 1'b1;
                    wr_word.start = 1'b0;
                    wr_word.last  = 1'b0;
                    wr_word.word  = pad_word;
                    if (bits_reg[0] == 1'b1) // flag: extra block in progress
                        wr_word.word = 32'd0;
                    if (widx == 4'd15 && bits_reg[0] == 1'b0)
                    begin
                        wr_word.last = 1'b1;
                        state_next   = ST_BYTES;
                        fresh_next   = 1'b1;
                        fill_next    = 6'd0;
                    end
                    else
                    begin
                        if (widx == 4'd15)
                            bits_next[0] = 1'b0;
                        fill_next = fill_reg + 6'd4;
                    end
                end
            end
            default: state_next = ST_BYTES;
        endcase
        // extra block needed: 0x80 word went to word 14 or 15 (or wrapped to 0)
        if (state_reg == ST_BYTES && accept && func == FUNC_FINISH
            && fill_reg[5:2] >= 4'd14)
        begin
            bits_next[0] = 1'b1;   // length bits are 0 mod 8, bit 0 is free
            if (fill_reg[5:2] == 4'd15)
                bits_next[0] = 1'b0; // next word is word 0 of the extra block
        end
    end

    // word 15 case: the extra block is wholly zeros up to length, so bit0
    // marker unneeded; but word 14 case: word 15 must be zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BYTES;
            fill_reg  <= 6'd0;
            fresh_reg <= 1'b1;
            start_reg <= 1'b0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            fresh_reg <= fresh_next;
            start_reg <= start_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        acc_reg   <= acc_next;
    end
endmodule

// File: rtl/shrbh_queue.sv
`timescale 1ns / 1ps
module shrbh_queue
    import shrbh_pkg::*;
#(
    parameter int Depth = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  shrbh_word_t wr_word,
    output logic        q_full,
    input  logic        rd_en,
    output logic        q_valid,
    output shrbh_word_t rd_word
);
    localparam int AW = $clog2(Depth);
    shrbh_word_t mem_reg [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign q_full  = (cnt_reg == (AW+1)'(Depth));
    assign q_valid = (cnt_reg != '0);
    assign rd_word = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_word;
    end
endmodule

// File: rtl/shrbh_core.sv
`timescale 1ns / 1ps
// Message schedule window plus one round per cycle when not starved of words; digest output register.
module shrbh_core
    import shrbh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  shrbh_word_t  rd_word,
    output logic         rd_en,
    input  logic [255:0] chain_cfg,
    output logic         empty,
    input  logic         pop,
    output logic [31:0]  digest_word,
    output logic [2:0]   word_index,
    output logic         last_word
);
    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]   state_reg;
    logic [6:0]   rnd_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic         last_reg;
    logic [2:0]   oidx_reg;

    logic [31:0]  wt, w_new, s0, s1, t1, t2, e, a;
    logic         take;
    logic [5:0]   r6;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign r6 = rnd_reg[5:0];
    // load only peeks at the head word; rounds 0..15 consume it
    assign take = q_valid && (state_reg == ST_RUN) && (rnd_reg < 7'd16);
    assign rd_en = take;
    assign s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign wt = (rnd_reg < 7'd16) ? rd_word.word : w_new;
    assign e = v_reg[4];
    assign a = v_reg[0];
    assign t1 = v_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(r6) + wt;
    assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign empty       = (state_reg != ST_OUT);
    assign digest_word = h_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

    logic step;
    assign step = (state_reg == ST_RUN) && (rnd_reg >= 7'd16 || q_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                    if (q_valid)
                        state_reg <= ST_RUN;
                ST_RUN:
                    if (step)
                    begin
                        if (rnd_reg == 7'd15)
                            last_reg <= rd_word.last;
                        if (rnd_reg == 7'd63)
                        begin
                            rnd_reg   <= '0;
                            state_reg <= ST_ADD;
                        end
                        else
                            rnd_reg <= rnd_reg + 7'd1;
                    end
                ST_ADD:
                    state_reg <= last_reg ? ST_OUT : ST_LOAD;
                ST_OUT:
                    if (pop)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                            state_reg <= ST_LOAD;
                    end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && q_valid)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (rd_word.start)
                begin
                    h_reg[i] <= chain_cfg[255-32*i -: 32];
                    v_reg[i] <= chain_cfg[255-32*i -: 32];
                end
                else
                    v_reg[i] <= h_reg[i];
            end
        end
        else if (step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wt;
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
        else if (state_reg == ST_ADD)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end
endmodule

// File: bench/sha256_resumable_byte_hasher_tb.sv
`timescale 1ns / 1ps
module sha256_resumable_byte_hasher_tb;
    import shrbh_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               func;
    logic [7:0]         data_byte;
    logic               empty;
    logic               pop;
    logic [31:0]        digest_word;
    logic [2:0]         word_index;
    logic               last_word;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [63:0]        cfg_data;

    localparam int WatchdogLimit = 20000;
    localparam int SettleCycles  = 300;   // two compressions plus slack
    localparam int HoldCycles    = 300;   // long receiver hold-off
    localparam int PhaseBeats    = 48;    // beats per idling phase

    sha256_resumable_byte_hasher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Hash predictor: own copy of registers and message state
    // ------------------------------------------------------------------
    typedef struct {
        bit [31:0] word;
        bit [2:0]  idx;
        bit        last;
    } digest_beat_t;

    digest_beat_t digest_q[$];

    bit [63:0] shadow_regs [CfgRegs];
    bit [31:0] hash_state [8];
    bit [7:0]  blk_bytes [64];
    int        blk_fill;
    bit [63:0] msg_bytes;
    bit        msg_fresh;

    bit [31:0] k_tab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic bit [31:0] rotr(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of blk_bytes into hash_state
    function automatic void compress_block();
        bit [31:0] w [64];
        bit [31:0] v [8];
        bit [31:0] t1;
        bit [31:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        v = hash_state;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endfunction

    // Advance the predictor by one accepted beat; a finish queues 8 digest words
    function automatic void hash_beat(bit fn, bit [7:0] b);
        bit [63:0]    bit_len;
        int           pos;
        digest_beat_t d;
        if (msg_fresh)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hash_state[2*i]   = shadow_regs[i][63:32];
                hash_state[2*i+1] = shadow_regs[i][31:0];
            end
            msg_bytes = shadow_regs[REG_LEN];
            blk_fill  = 0;
            msg_fresh = 1'b0;
        end
        if (fn == FUNC_ABSORB)
        begin
            blk_bytes[blk_fill] = b;
            blk_fill++;
            msg_bytes++;
            if (blk_fill == 64)
            begin
                compress_block();
                blk_fill = 0;
            end
            return;
        end
        bit_len = msg_bytes << 3;
        pos = blk_fill;
        blk_bytes[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                blk_bytes[pos] = 8'h00;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            blk_bytes[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            blk_bytes[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            d.word = hash_state[i];
            d.idx  = i[2:0];
            d.last = (i == 7);
            digest_q = {digest_q, d};
        end
        blk_fill  = 0;
        msg_fresh = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Shared run state
    // ------------------------------------------------------------------
    int  mismatches;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  quiet_cycles;

    task automatic note_mismatch(string what, bit [31:0] want, bit [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Sender side: called at a rising edge, returns at the accepting edge
    // ------------------------------------------------------------------
    task automatic send_beat(bit fn, bit [7:0] b);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        func      <= fn;
        data_byte <= b;
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        while (!taken);
        hash_beat(fn, b);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only when idle: drained, then the engine left to settle
    task automatic write_reg(bit [CfgIdxW-1:0] idx, bit [63:0] val);
        bit taken;
        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        if (idx < CfgRegs)
            shadow_regs[idx] = val;
    endtask

    task automatic send_message(int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            send_beat(FUNC_ABSORB, 8'($urandom));
        send_beat(FUNC_FINISH, 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Receiver: pop driven at the rising edge, beat taken at the falling edge
    // where everything is stable
    // ------------------------------------------------------------------
    initial
    begin
        int           hold_left;
        digest_beat_t want;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && pop && !empty)
            begin
                if (digest_q.size() == 0)
                    note_mismatch("unexpected digest beat", 32'h0, digest_word);
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_word !== want.word)
                        note_mismatch("digest_word", want.word, digest_word);
                    if (word_index !== want.idx)
                        note_mismatch("word_index", 32'(want.idx), 32'(word_index));
                    if (last_word !== want.last)
                        note_mismatch("last_word", 32'(want.last), 32'(last_word));
                end
            end
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles without any handshake on any port
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table: config writes and beats; a finish row may carry the
    // well-known first digest word where the start state is the standard IV
    // ------------------------------------------------------------------
    typedef enum bit {ROW_REG, ROW_BEAT} row_kind_t;
    typedef struct {
        row_kind_t          kind;
        bit [CfgIdxW-1:0]   idx;
        bit [63:0]          val;
        bit                 fn;
        bit [7:0]           b;
        int                 reps;    // beat repeated, byte stepping by one
        bit                 known;
        bit [31:0]          word0;
    } stim_row_t;

    stim_row_t directed_rows [] = '{
        // empty message from the all-zero reset registers
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'h00, 1, 1'b0, 32'h0},
        // standard IV, zero length
        '{ROW_REG, REG_AB,  64'h6a09e667_bb67ae85, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        '{ROW_REG, REG_CD,  64'h3c6ef372_a54ff53a, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        '{ROW_REG, REG_EF,  64'h510e527f_9b05688c, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        '{ROW_REG, REG_GH,  64'h1f83d9ab_5be0cd19, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        '{ROW_REG, REG_LEN, 64'h0, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        // plain SHA-256 of the empty string and of "abc"
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'h00, 1, 1'b1, 32'he3b0c442},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_ABSORB, 8'h61, 3, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'hff, 1, 1'b1, 32'hba7816bf},
        // byte extremes; finish byte ignored
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_ABSORB, 8'h00, 1, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_ABSORB, 8'hff, 1, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'h00, 1, 1'b0, 32'h0},
        // padding fits, needs an extra block, exact block boundary
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_ABSORB, 8'h10, 55, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'h00, 1, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_ABSORB, 8'h20, 56, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'h00, 1, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_ABSORB, 8'hc0, 64, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'h00, 1, 1'b0, 32'h0},
        // out-of-range index must be ignored
        '{ROW_REG, 3'd7, 64'hffff_ffff_ffff_ffff, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        '{ROW_REG, 3'd5, 64'h1234_5678_9abc_def0, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        // byte count wraps past 2^64
        '{ROW_REG, REG_LEN, 64'hffff_ffff_ffff_ffc0, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_ABSORB, 8'h5a, 70, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'h00, 1, 1'b0, 32'h0},
        // start length not a multiple of 64
        '{ROW_REG, REG_LEN, 64'h3, 1'b0, 8'h00, 0, 1'b0, 32'h0},
        '{ROW_BEAT, REG_AB, 64'h0, FUNC_FINISH, 8'h00, 1, 1'b0, 32'h0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int        beats_left;
        int        n_bytes;
        bit [63:0] reg_val;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        func           = FUNC_ABSORB;
        data_byte      = 8'h00;
        cfg_valid      = 1'b0;
        cfg_index      = REG_AB;
        cfg_data       = 64'h0;
        for (int i = 0; i < CfgRegs; i++)
            shadow_regs[i] = 64'h0;
        for (int i = 0; i < 8; i++)
            hash_state[i] = 32'h0;
        blk_fill  = 0;
        msg_bytes = 64'h0;
        msg_fresh = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_REG)
                write_reg(directed_rows[r].idx, directed_rows[r].val);
            else
            begin
                for (int j = 0; j < directed_rows[r].reps; j++)
                    send_beat(directed_rows[r].fn, directed_rows[r].b + 8'(j));
                if (directed_rows[r].known
                    && digest_q[digest_q.size()-8].word !== directed_rows[r].word0)
                    note_mismatch("known digest", directed_rows[r].word0,
                                  digest_q[digest_q.size()-8].word);
            end
        end

        // Four idling phases, each preceded by a fresh register setting
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int r = 0; r < CfgRegs; r++)
            begin
                case (ph)
                    0: reg_val = 64'h0;
                    1: reg_val = 64'hffff_ffff_ffff_ffff;
                    default: reg_val = {$urandom, $urandom};
                endcase
                // length is normally a whole number of blocks
                if (r == REG_LEN && ph >= 2 && $urandom_range(3) != 0)
                    reg_val[5:0] = 6'h0;
                write_reg(r[CfgIdxW-1:0], reg_val);
            end
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            beats_left = PhaseBeats;
            while (beats_left > 0)
            begin
                // receiver holds off while the sender keeps streaming
                if (ph == 0 && beats_left == PhaseBeats)
                    hold_req = 1'b1;
                // sender pauses for the pipeline to empty
                if (ph == 3 && beats_left < PhaseBeats / 2 && digest_q.size() != 0)
                    wait_drained();
                if ($urandom_range(9) == 0)
                    n_bytes = $urandom_range(130, 56);
                else
                    n_bytes = $urandom_range(20);
                if (n_bytes > beats_left - 1)
                    n_bytes = beats_left - 1;
                beats_left -= n_bytes + 1;
                send_message(n_bytes);
            end
        end

        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/shrbh_pkg.sv
rtl/shrbh_front.sv
rtl/shrbh_queue.sv
rtl/shrbh_core.sv
rtl/sha256_resumable_byte_hasher.sv
bench/sha256_resumable_byte_hasher_tb.sv
